FILE: rtl/rvex_pkg.sv
// ----------------------------------------------------------------------------
// rvex_pkg
// Shared constants and types of the RV32I execute unit.
// ----------------------------------------------------------------------------
package rvex_pkg;

	localparam int RVEX_MEM_BYTES = 65536;

	// instruction classes
	localparam logic [3:0] OP_LUI    = 4'd0;
	localparam logic [3:0] OP_AUIPC  = 4'd1;
	localparam logic [3:0] OP_JAL    = 4'd2;
	localparam logic [3:0] OP_JALR   = 4'd3;
	localparam logic [3:0] OP_BRANCH = 4'd4;
	localparam logic [3:0] OP_LOAD   = 4'd5;
	localparam logic [3:0] OP_STORE  = 4'd6;
	localparam logic [3:0] OP_OPIMM  = 4'd7;
	localparam logic [3:0] OP_OP     = 4'd8;
	localparam logic [3:0] OP_SYSTEM = 4'd9;

	// status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_HALT    = 3'd1;
	localparam logic [2:0] ST_BADF3   = 3'd2;
	localparam logic [2:0] ST_EBREAK  = 3'd3;
	localparam logic [2:0] ST_BADCALL = 3'd4;

	// funct3 codes
	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SR   = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;

	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;
	localparam logic [2:0] F3_BLT  = 3'd4;
	localparam logic [2:0] F3_BGE  = 3'd5;
	localparam logic [2:0] F3_BLTU = 3'd6;
	localparam logic [2:0] F3_BGEU = 3'd7;

	localparam logic [2:0] F3_B  = 3'd0;
	localparam logic [2:0] F3_H  = 3'd1;
	localparam logic [2:0] F3_W  = 3'd2;
	localparam logic [2:0] F3_BU = 3'd4;
	localparam logic [2:0] F3_HU = 3'd5;

	localparam logic [4:0]  REG_A7    = 5'd17;
	localparam logic [31:0] CALL_EXIT = 32'd10;

	typedef struct packed {
		logic       rd;
		logic [3:0] we;
	} rvex_dmem_ctl_t;

endpackage

FILE: rtl/rvex_req_if.sv
// ----------------------------------------------------------------------------
// rvex_req_if
// Decoded instruction channel.
// ----------------------------------------------------------------------------
interface rvex_req_if;
	logic        valid;
	logic        ready;
	logic [3:0]  op;
	logic [2:0]  funct3;
	logic        alt;
	logic [4:0]  rd;
	logic [4:0]  rs1;
	logic [4:0]  rs2;
	logic [31:0] imm;

	modport source (output valid, op, funct3, alt, rd, rs1, rs2, imm, input ready);
	modport sink (input valid, op, funct3, alt, rd, rs1, rs2, imm, output ready);
endinterface

FILE: rtl/rvex_rsp_if.sv
// ----------------------------------------------------------------------------
// rvex_rsp_if
// Execution result channel.
// ----------------------------------------------------------------------------
interface rvex_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] next_pc;
	logic        wb_valid;
	logic [4:0]  wb_reg;
	logic [31:0] wb_value;

	modport source (output valid, status, next_pc, wb_valid, wb_reg, wb_value, input ready);
	modport sink (input valid, status, next_pc, wb_valid, wb_reg, wb_value, output ready);
endinterface

FILE: rtl/rvex_dmem.sv
// ----------------------------------------------------------------------------
// rvex_dmem
// Byte-lane data memory, four lanes of MEM_BYTES/4 bytes, one read and one
// write per lane per cycle, clearing pass after reset.
// ----------------------------------------------------------------------------
module rvex_dmem #(
	parameter int MEM_BYTES = rvex_pkg::RVEX_MEM_BYTES
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  rvex_pkg::rvex_dmem_ctl_t             ctl,
	input  logic [$clog2(MEM_BYTES)-3:0]         row [4],
	input  logic [7:0]                           wdata [4],
	output logic [7:0]                           rdata [4],
	output logic                                 busy
);
	import rvex_pkg::*;

	localparam int ROWS = MEM_BYTES / 4;
	localparam int RW   = $clog2(MEM_BYTES) - 2;
	localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

	logic          busy_q;
	logic [RW-1:0] clr_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b1;
			clr_cnt_q <= '0;
		end else if (busy_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == LAST_ROW) busy_q <= 1'b0;
		end
	end

	assign busy = busy_q;

	for (genvar l = 0; l < 4; l++) begin : g_lane
		logic [7:0]    mem [ROWS];
		logic          wen;
		logic [RW-1:0] waddr;
		logic [7:0]    wd;

		assign wen   = busy_q || ctl.we[l];
		assign waddr = busy_q ? clr_cnt_q : row[l];
		assign wd    = busy_q ? 8'h00 : wdata[l];

		always_ff @(posedge clk) begin
			if (wen) mem[waddr] <= wd;
			if (ctl.rd) rdata[l] <= mem[row[l]];
		end
	end

	a_no_access_clear: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (ctl.we == 4'b0000 && !ctl.rd))
		else $error("data memory accessed during clearing pass");
	a_clear_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && clr_cnt_q == LAST_ROW) |=> !busy_q)
		else $error("clearing pass did not end");
	a_busy_stays_low: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |=> !busy_q)
		else $error("clearing pass restarted");

endmodule

FILE: rtl/rv32i_execute_unit.sv
// ----------------------------------------------------------------------------
// rv32i_execute_unit
// Executes decoded RV32I instructions against register file, pc and memory.
// ----------------------------------------------------------------------------
// Three stages: a word is taken while the register file is read, the second
// stage computes results, pc and the memory address and issues the load or
// store, the third forms load data, writes the register file and loads the
// output register. One word per cycle is taken when words are independent
// and the output is not held; a word that reads a register written by the
// word just ahead of it waits in the second stage until that write is done.
// After reset the data memory is cleared one 32-bit row per cycle, and no
// word is taken until every row is cleared. MEM_BYTES must be a power of
// two; addresses wrap modulo MEM_BYTES byte by byte.
module rv32i_execute_unit #(
	parameter int MEM_BYTES = rvex_pkg::RVEX_MEM_BYTES
) (
	input  logic      clk,
	input  logic      arst_n,
	rvex_req_if.sink  req,
	rvex_rsp_if.source rsp
);
	import rvex_pkg::*;

	localparam int AW = $clog2(MEM_BYTES);
	localparam int RW = AW - 2;

	// register file
	logic [31:0] rf_mem [32];
	logic [31:0] rf_vld_q;
	logic        rf_we;
	logic [4:0]  rf_waddr;
	logic [31:0] rf_wdata;
	logic [4:0]  rb_addr;

	// handshake and stage control
	logic clr_busy, acc, b_adv, c_adv, b_free, c_free, o_free, hazard;
	logic b_vld_q, c_vld_q, o_vld_q;

	// stage 1
	logic [3:0]  op_s1;
	logic [2:0]  f3_s1;
	logic        alt_s1;
	logic [4:0]  rd_s1, ra_s1, rb_s1;
	logic [31:0] imm_s1;
	logic [31:0] rfa_s1, rfb_s1;
	logic        va_s1, vb_s1;
	logic        ovra_q, ovrb_q;
	logic [31:0] ovda_q, ovdb_q;

	// architectural state
	logic [31:0] pc_q;
	logic        halted_q;

	// stage 1 results
	logic [31:0] a, b, i12, opb, alu_y, addr, npc, val;
	logic [2:0]  st;
	logic        wr, take, ld, st_we, halt_set;
	logic [1:0]  off;
	logic [RW-1:0] row;

	// stage 2
	logic [2:0]  st_s2, f3_s2;
	logic [31:0] npc_s2, val_s2;
	logic        wr_s2, ld_s2;
	logic [4:0]  rd_s2;
	logic [1:0]  off_s2;
	logic [31:0] res_s2;

	// data memory
	rvex_dmem_ctl_t dm_ctl;
	logic [RW-1:0]  dm_row [4];
	logic [7:0]     dm_wdata [4];
	logic [7:0]     dm_rdata [4];
	logic [7:0]     lb [4];

	// output register
	logic [2:0]  o_st_q;
	logic [31:0] o_npc_q, o_val_q;
	logic        o_wr_q;
	logic [4:0]  o_rd_q;

	// ---------------- control ----------------
	assign o_free = !o_vld_q || rsp.ready;
	assign c_adv  = c_vld_q && o_free;
	assign c_free = !c_vld_q || o_free;
	assign hazard = c_vld_q && wr_s2 && (rd_s2 == ra_s1 || rd_s2 == rb_s1);
	assign b_adv  = b_vld_q && c_free && !hazard;
	assign b_free = !b_vld_q || b_adv;
	assign req.ready = !clr_busy && b_free;
	assign acc    = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_vld_q <= 1'b0;
			c_vld_q <= 1'b0;
			o_vld_q <= 1'b0;
		end else begin
			if (acc) b_vld_q <= 1'b1;
			else if (b_adv) b_vld_q <= 1'b0;
			if (b_adv) c_vld_q <= 1'b1;
			else if (c_adv) c_vld_q <= 1'b0;
			if (c_adv) o_vld_q <= 1'b1;
			else if (rsp.ready) o_vld_q <= 1'b0;
		end
	end

	// ---------------- register file ----------------
	assign rb_addr  = (req.op == OP_SYSTEM) ? REG_A7 : req.rs2;
	assign rf_we    = c_adv && wr_s2;
	assign rf_waddr = rd_s2;
	assign rf_wdata = res_s2;

	always_ff @(posedge clk) begin
		if (rf_we) rf_mem[rf_waddr] <= rf_wdata;
		if (acc) begin
			rfa_s1 <= rf_mem[req.rs1];
			rfb_s1 <= rf_mem[rb_addr];
		end
	end

	// valid bits, read indices and write-after-read capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
			va_s1    <= 1'b0;
			vb_s1    <= 1'b0;
			ra_s1    <= '0;
			rb_s1    <= '0;
			ovra_q   <= 1'b0;
			ovrb_q   <= 1'b0;
		end else begin
			if (rf_we) rf_vld_q[rf_waddr] <= 1'b1;
			if (acc) begin
				va_s1  <= rf_vld_q[req.rs1];
				vb_s1  <= rf_vld_q[rb_addr];
				ra_s1  <= req.rs1;
				rb_s1  <= rb_addr;
				ovra_q <= rf_we && rf_waddr == req.rs1;
				ovrb_q <= rf_we && rf_waddr == rb_addr;
			end else begin
				if (rf_we && rf_waddr == ra_s1) ovra_q <= 1'b1;
				if (rf_we && rf_waddr == rb_s1) ovrb_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc ? (rf_we && rf_waddr == req.rs1) : (rf_we && rf_waddr == ra_s1))
			ovda_q <= rf_wdata;
		if (acc ? (rf_we && rf_waddr == rb_addr) : (rf_we && rf_waddr == rb_s1))
			ovdb_q <= rf_wdata;
		if (acc) begin
			op_s1  <= req.op;
			f3_s1  <= req.funct3;
			alt_s1 <= req.alt;
			rd_s1  <= req.rd;
			imm_s1 <= req.imm;
		end
	end

	// ---------------- execute ----------------
	assign a   = ovra_q ? ovda_q : (va_s1 ? rfa_s1 : 32'd0);
	assign b   = ovrb_q ? ovdb_q : (vb_s1 ? rfb_s1 : 32'd0);
	assign i12 = {{20{imm_s1[11]}}, imm_s1[11:0]};
	assign opb = (op_s1 == OP_OP) ? b :
		((f3_s1 == F3_SLL || f3_s1 == F3_SR) ? {27'd0, imm_s1[4:0]} : i12);
	assign addr = a + i12;
	assign off  = addr[1:0];
	assign row  = addr[AW-1:2];

	always_comb begin
		case (f3_s1)
			F3_ADD:  alu_y = (op_s1 == OP_OP && alt_s1) ? a - opb : a + opb;
			F3_SLL:  alu_y = a << opb[4:0];
			F3_SLT:  alu_y = {31'd0, $signed(a) < $signed(opb)};
			F3_SLTU: alu_y = {31'd0, a < opb};
			F3_XOR:  alu_y = a ^ opb;
			F3_SR:   alu_y = alt_s1 ? 32'($signed(a) >>> opb[4:0]) : a >> opb[4:0];
			F3_OR:   alu_y = a | opb;
			default: alu_y = a & opb;
		endcase
	end

	always_comb begin
		npc      = pc_q + 32'd4;
		st       = ST_OK;
		wr       = 1'b0;
		val      = 32'd0;
		take     = 1'b0;
		ld       = 1'b0;
		st_we    = 1'b0;
		halt_set = 1'b0;
		if (halted_q) begin
			st  = ST_HALT;
			npc = pc_q;
		end else begin
			case (op_s1)
				OP_LUI: begin
					wr  = 1'b1;
					val = imm_s1;
				end
				OP_AUIPC: begin
					wr  = 1'b1;
					val = pc_q + imm_s1;
				end
				OP_JAL: begin
					wr  = 1'b1;
					val = pc_q + 32'd4;
					npc = pc_q + {{11{imm_s1[20]}}, imm_s1[20:0]};
				end
				OP_JALR: begin
					wr  = 1'b1;
					val = pc_q + 32'd4;
					npc = {addr[31:1], 1'b0};
				end
				OP_BRANCH: begin
					case (f3_s1)
						F3_BEQ:  take = a == b;
						F3_BNE:  take = a != b;
						F3_BLT:  take = $signed(a) < $signed(b);
						F3_BGE:  take = $signed(a) >= $signed(b);
						F3_BLTU: take = a < b;
						F3_BGEU: take = a >= b;
						default: st = ST_BADF3;
					endcase
					if (take) npc = pc_q + {{19{imm_s1[12]}}, imm_s1[12:0]};
				end
				OP_LOAD: begin
					case (f3_s1)
						F3_B, F3_H, F3_W, F3_BU, F3_HU: begin
							ld = 1'b1;
							wr = 1'b1;
						end
						default: st = ST_BADF3;
					endcase
				end
				OP_STORE: begin
					case (f3_s1)
						F3_B, F3_H, F3_W: st_we = 1'b1;
						default: st = ST_BADF3;
					endcase
				end
				OP_OPIMM, OP_OP: begin
					wr  = 1'b1;
					val = alu_y;
				end
				OP_SYSTEM: begin
					if (imm_s1 != 32'd0) st = ST_EBREAK;
					else if (b == CALL_EXIT) begin
						st       = ST_HALT;
						halt_set = 1'b1;
					end else st = ST_BADCALL;
				end
				default: st = ST_BADF3;
			endcase
		end
		if (st != ST_OK && st != ST_HALT) begin
			wr  = 1'b0;
			npc = pc_q;
		end
		if (rd_s1 == 5'd0) wr = 1'b0;
	end

	// byte lanes: lane l holds byte (l - off) of the access
	always_comb begin
		logic [1:0] k;
		for (int l = 0; l < 4; l++) begin
			k = 2'(l) - off;
			dm_row[l]   = (2'(l) >= off) ? row : row + 1'b1;
			dm_wdata[l] = b[8*k +: 8];
			dm_ctl.we[l] = b_adv && st_we &&
				(f3_s1 == F3_W || (f3_s1 == F3_H && k <= 2'd1) || k == 2'd0);
		end
		dm_ctl.rd = b_adv && ld;
	end

	rvex_dmem #(.MEM_BYTES(MEM_BYTES)) u_dmem (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (dm_ctl),
		.row    (dm_row),
		.wdata  (dm_wdata),
		.rdata  (dm_rdata),
		.busy   (clr_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q     <= '0;
			halted_q <= 1'b0;
		end else if (b_adv) begin
			pc_q     <= npc;
			halted_q <= halted_q || halt_set;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) wr_s2 <= 1'b0;
		else if (b_adv) wr_s2 <= wr;
	end

	always_ff @(posedge clk) begin
		if (b_adv) begin
			st_s2  <= st;
			npc_s2 <= npc;
			val_s2 <= val;
			rd_s2  <= rd_s1;
			ld_s2  <= ld;
			f3_s2  <= f3_s1;
			off_s2 <= off;
		end
	end

	// ---------------- load align and write-back ----------------
	always_comb begin
		for (int k = 0; k < 4; k++) lb[k] = dm_rdata[2'(k) + off_s2];
		res_s2 = val_s2;
		if (ld_s2) begin
			case (f3_s2)
				F3_B:    res_s2 = {{24{lb[0][7]}}, lb[0]};
				F3_H:    res_s2 = {{16{lb[1][7]}}, lb[1], lb[0]};
				F3_W:    res_s2 = {lb[3], lb[2], lb[1], lb[0]};
				F3_BU:   res_s2 = {24'd0, lb[0]};
				F3_HU:   res_s2 = {16'd0, lb[1], lb[0]};
				default: res_s2 = val_s2;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (c_adv) begin
			o_st_q  <= st_s2;
			o_npc_q <= npc_s2;
			o_wr_q  <= wr_s2;
			o_rd_q  <= wr_s2 ? rd_s2 : 5'd0;
			o_val_q <= wr_s2 ? res_s2 : 32'd0;
		end
	end

	assign rsp.valid    = o_vld_q;
	assign rsp.status   = o_st_q;
	assign rsp.next_pc  = o_npc_q;
	assign rsp.wb_valid = o_wr_q;
	assign rsp.wb_reg   = o_rd_q;
	assign rsp.wb_value = o_val_q;

	a_no_take_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !req.ready)
		else $error("word taken during memory clear");
	a_no_x0_write: assert property (@(posedge clk) disable iff (!arst_n)
		rf_we |-> rf_waddr != 5'd0)
		else $error("write to x0");
	a_pc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!b_adv |=> $stable(pc_q))
		else $error("pc changed without an executed word");
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halt flag cleared");
	a_hazard_stall: assert property (@(posedge clk) disable iff (!arst_n)
		hazard |-> !b_adv)
		else $error("dependent word advanced past pending write");

endmodule

FILE: bench/tb_rv32i_execute_unit.sv
// ----------------------------------------------------------------------------
// tb_rv32i_execute_unit
// Self-checking bench for the RV32I execute unit. Directed words cover every
// class, funct3 extreme, x0 writes, bad codes, ebreak and unknown ecall; then
// random programs run against a behavioral copy of the register file, pc and
// data memory. The run ends with an ecall halt and words issued while halted.
// ----------------------------------------------------------------------------
module tb_rv32i_execute_unit;
	import rvex_pkg::*;

	localparam int MEMB = RVEX_MEM_BYTES;
	localparam int MAW = $clog2(MEMB);
	localparam int N_RAND = 1620;
	localparam int WD_LIMIT = MEMB / 4 + 20000;

	typedef struct packed {
		logic [3:0]  op;
		logic [2:0]  funct3;
		logic        alt;
		logic [4:0]  rd;
		logic [4:0]  rs1;
		logic [4:0]  rs2;
		logic [31:0] imm;
	} instr_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] next_pc;
		logic        wb_valid;
		logic [4:0]  wb_reg;
		logic [31:0] wb_value;
	} exec_res_t;

	// directed row: word, whether the result is typed in, and that result
	typedef struct packed {
		instr_t    w;
		logic      fixed;
		exec_res_t r;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rvex_req_if req();
	rvex_rsp_if rsp();

	rv32i_execute_unit dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	always #5 clk = ~clk;

	// architectural copy
	logic [31:0] regs [32];
	logic [31:0] pc_q;
	logic [7:0]  dmem [MEMB];
	logic        halted_q;

	exec_res_t results_due[$];
	int errors = 0;
	int n_words = 0;
	int n_results = 0;
	int idle_cycles = 0;
	bit hold_rsp = 1'b0;

	function automatic logic [31:0] sx(input logic [31:0] v, input int bits);
		logic [31:0] m;
		m = (bits == 32) ? '1 : ((32'd1 << bits) - 1);
		v = v & m;
		if (v[bits-1])
			v = v | ~m;
		return v;
	endfunction

	function automatic logic [31:0] alu_calc(input logic [2:0] f3, input logic sub,
			input logic arith, input logic [31:0] a, input logic [31:0] b);
		logic [4:0] sh;
		sh = b[4:0];
		case (f3)
			F3_ADD:  return sub ? a - b : a + b;
			F3_SLL:  return a << sh;
			F3_SLT:  return {31'd0, $signed(a) < $signed(b)};
			F3_SLTU: return {31'd0, a < b};
			F3_XOR:  return a ^ b;
			F3_SR:   return arith ? 32'($signed(a) >>> sh) : a >> sh;
			F3_OR:   return a | b;
			default: return a & b;
		endcase
	endfunction

	// memory size is a power of two, so truncation wraps the address
	function automatic logic [7:0] mrd(input logic [31:0] addr);
		return dmem[MAW'(addr)];
	endfunction

	function automatic exec_res_t execute(input instr_t w);
		exec_res_t r;
		logic [31:0] a, b, npc, val, addr;
		logic wr, take;
		logic [2:0] st;
		a = regs[w.rs1];
		b = regs[w.rs2];
		npc = pc_q + 32'd4;
		val = '0;
		wr = 1'b0;
		take = 1'b0;
		st = ST_OK;
		addr = '0;
		if (halted_q) begin
			r = '{ST_HALT, pc_q, 1'b0, 5'd0, 32'd0};
			return r;
		end
		case (w.op)
			OP_LUI: begin wr = 1'b1; val = w.imm; end
			OP_AUIPC: begin wr = 1'b1; val = pc_q + w.imm; end
			OP_JAL: begin wr = 1'b1; val = npc; npc = pc_q + sx(w.imm, 21); end
			OP_JALR: begin
				wr = 1'b1;
				val = npc;
				npc = (a + sx(w.imm, 12)) & ~32'd1;
			end
			OP_BRANCH: begin
				case (w.funct3)
					F3_BEQ:  take = a == b;
					F3_BNE:  take = a != b;
					F3_BLT:  take = $signed(a) < $signed(b);
					F3_BGE:  take = $signed(a) >= $signed(b);
					F3_BLTU: take = a < b;
					F3_BGEU: take = a >= b;
					default: st = ST_BADF3;
				endcase
				if (take)
					npc = pc_q + sx(w.imm, 13);
			end
			OP_LOAD: begin
				addr = a + sx(w.imm, 12);
				case (w.funct3)
					F3_B:  val = sx({24'd0, mrd(addr)}, 8);
					F3_H:  val = sx({16'd0, mrd(addr + 32'd1), mrd(addr)}, 16);
					F3_W:  val = {mrd(addr + 32'd3), mrd(addr + 32'd2), mrd(addr + 32'd1),
						mrd(addr)};
					F3_BU: val = {24'd0, mrd(addr)};
					F3_HU: val = {16'd0, mrd(addr + 32'd1), mrd(addr)};
					default: st = ST_BADF3;
				endcase
				wr = (st == ST_OK);
			end
			OP_STORE: begin
				addr = a + sx(w.imm, 12);
				if (w.funct3 > F3_W)
					st = ST_BADF3;
				else
					for (int k = 0; k < (1 << w.funct3); k++)
						dmem[MAW'(addr + 32'(k))] = b[8*k +: 8];
			end
			OP_OPIMM: begin
				wr = 1'b1;
				val = alu_calc(w.funct3, 1'b0, w.alt, a,
					(w.funct3 == F3_SLL || w.funct3 == F3_SR) ?
					{27'd0, w.imm[4:0]} : sx(w.imm, 12));
			end
			OP_OP: begin wr = 1'b1; val = alu_calc(w.funct3, w.alt, w.alt, a, b); end
			OP_SYSTEM: begin
				if (w.imm != 32'd0)
					st = ST_EBREAK;
				else if (regs[REG_A7] == CALL_EXIT) begin
					st = ST_HALT;
					halted_q = 1'b1;
				end else
					st = ST_BADCALL;
			end
			default: st = ST_BADF3;
		endcase
		if (st != ST_OK && st != ST_HALT) begin
			wr = 1'b0;
			npc = pc_q;
		end
		if (wr && w.rd != 5'd0)
			regs[w.rd] = val;
		else begin
			wr = 1'b0;
			val = '0;
		end
		pc_q = npc;
		r = '{st, npc, wr, wr ? w.rd : 5'd0, val};
		return r;
	endfunction

	// sender: drives at the falling edge, holds until accepted
	task automatic send(input instr_t w);
		@(negedge clk);
		req.valid <= 1'b1;
		{req.op, req.funct3, req.alt, req.rd, req.rs1, req.rs2, req.imm} <= w;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		results_due.push_back(execute(w));
		n_words++;
	endtask

	task automatic send_gap(input int n);
		if (n > 0) begin
			@(negedge clk);
			req.valid <= 1'b0;
			repeat (n - 1)
				@(negedge clk);
		end
	endtask

	task automatic drain;
		@(negedge clk);
		req.valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
	endtask

	// mostly small, biased-register random words; a7 kept away from 10
	function automatic instr_t rand_word();
		instr_t w;
		int k;
		w.op = 4'($urandom_range(0, 9));
		if ($urandom_range(0, 60) == 0)
			w.op = 4'($urandom_range(10, 15));
		w.funct3 = 3'($urandom);
		w.alt = 1'($urandom);
		w.rd = 5'($urandom_range(0, 31));
		if (w.rd == REG_A7)
			w.rd = 5'd16;
		w.rs1 = $urandom_range(0, 3) == 0 ? 5'($urandom) : 5'($urandom_range(0, 7));
		w.rs2 = $urandom_range(0, 3) == 0 ? 5'($urandom) : 5'($urandom_range(0, 7));
		k = $urandom_range(0, 3);
		w.imm = k == 0 ? $urandom : (k == 1 ? 32'($urandom_range(0, 64)) :
			(k == 2 ? -32'($urandom_range(0, 64)) : {$urandom} & 32'h0000_0fff));
		if (w.op == OP_SYSTEM && $urandom_range(0, 1))
			w.imm = '0;
		return w;
	endfunction

	dir_row_t dir_tab[$];

	function automatic void add_row(input instr_t w, input logic fx, input exec_res_t r);
		dir_tab.push_back('{w, fx, r});
	endfunction

	// response side
	always @(negedge clk) begin
		if (!arst_n)
			rsp.ready <= 1'b0;
		else if (hold_rsp)
			rsp.ready <= 1'b0;
		else
			rsp.ready <= ($urandom_range(0, 9) < 7) || ($time / 2000) % 3 == 0;
	end

	always @(posedge clk) begin
		exec_res_t got, want;
		if (rsp.valid && rsp.ready) begin
			got = '{rsp.status, rsp.next_pc, rsp.wb_valid, rsp.wb_reg, rsp.wb_value};
			n_results++;
			if (results_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected result %h", $time, got);
			end else begin
				want = results_due.pop_front();
				if (got.status !== want.status) begin
					errors++;
					$display("%0t: status exp %0d got %0d", $time, want.status, got.status);
				end
				if (got.next_pc !== want.next_pc) begin
					errors++;
					$display("%0t: next_pc exp %h got %h", $time, want.next_pc, got.next_pc);
				end
				if (got.wb_valid !== want.wb_valid) begin
					errors++;
					$display("%0t: wb_valid exp %0b got %0b", $time, want.wb_valid,
						got.wb_valid);
				end
				if (got.wb_reg !== want.wb_reg) begin
					errors++;
					$display("%0t: wb_reg exp %0d got %0d", $time, want.wb_reg, got.wb_reg);
				end
				if (got.wb_value !== want.wb_value) begin
					errors++;
					$display("%0t: wb_value exp %h got %h", $time, want.wb_value,
						got.wb_value);
				end
			end
		end
	end

	// watchdog: cycles with no word moving on either side
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WD_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		exec_res_t fx_r;
		instr_t w;
		int burst;
		req.valid = 1'b0;
		{req.op, req.funct3, req.alt, req.rd, req.rs1, req.rs2, req.imm} = '0;
		rsp.ready = 1'b0;
		foreach (regs[i])
			regs[i] = '0;
		foreach (dmem[i])
			dmem[i] = '0;
		pc_q = '0;
		halted_q = 1'b0;

		// typed-in rows first; pc advances by 4 per ok word
		add_row('{OP_LUI, 3'd0, 1'b0, 5'd1, 5'd0, 5'd0, 32'hffff_f000}, 1'b1,
			'{ST_OK, 32'd4, 1'b1, 5'd1, 32'hffff_f000});
		add_row('{OP_LUI, 3'd0, 1'b0, 5'd0, 5'd0, 5'd0, 32'hffff_ffff}, 1'b1,
			'{ST_OK, 32'd8, 1'b0, 5'd0, 32'd0});
		add_row('{OP_BRANCH, 3'd2, 1'b0, 5'd3, 5'd1, 5'd1, 32'd8}, 1'b1,
			'{ST_BADF3, 32'd8, 1'b0, 5'd0, 32'd0});
		add_row('{4'd15, 3'd7, 1'b1, 5'd31, 5'd31, 5'd31, 32'hffff_ffff}, 1'b1,
			'{ST_BADF3, 32'd8, 1'b0, 5'd0, 32'd0});
		add_row('{OP_SYSTEM, 3'd0, 1'b0, 5'd0, 5'd0, 5'd0, 32'd1}, 1'b1,
			'{ST_EBREAK, 32'd8, 1'b0, 5'd0, 32'd0});
		add_row('{OP_SYSTEM, 3'd7, 1'b0, 5'd0, 5'd0, 5'd0, 32'd0}, 1'b1,
			'{ST_BADCALL, 32'd8, 1'b0, 5'd0, 32'd0});
		add_row('{OP_LOAD, 3'd3, 1'b0, 5'd2, 5'd0, 5'd0, 32'd0}, 1'b1,
			'{ST_BADF3, 32'd8, 1'b0, 5'd0, 32'd0});
		add_row('{OP_STORE, 3'd3, 1'b0, 5'd2, 5'd0, 5'd0, 32'd0}, 1'b1,
			'{ST_BADF3, 32'd8, 1'b0, 5'd0, 32'd0});
		// predictor-checked rows
		add_row('{OP_AUIPC, 3'd0, 1'b0, 5'd2, 5'd0, 5'd0, 32'h8000_0000}, 1'b0, '0);
		add_row('{OP_OPIMM, F3_ADD, 1'b0, 5'd3, 5'd1, 5'd0, 32'h0000_0800}, 1'b0, '0);
		add_row('{OP_OPIMM, F3_SR, 1'b1, 5'd4, 5'd1, 5'd0, 32'hffff_ffff}, 1'b0, '0);
		add_row('{OP_OPIMM, F3_SLTU, 1'b0, 5'd5, 5'd0, 5'd0, 32'h0000_0fff}, 1'b0, '0);
		add_row('{OP_OP, F3_ADD, 1'b1, 5'd6, 5'd0, 5'd1, 32'd0}, 1'b0, '0);
		add_row('{OP_OP, F3_SLT, 1'b0, 5'd7, 5'd1, 5'd6, 32'd0}, 1'b0, '0);
		add_row('{OP_OP, F3_SLL, 1'b0, 5'd8, 5'd1, 5'd4, 32'd0}, 1'b0, '0);
		// store word at address -1: wraps to the top and the bottom of memory
		add_row('{OP_STORE, F3_W, 1'b0, 5'd0, 5'd0, 5'd1, 32'hffff_ffff}, 1'b0, '0);
		add_row('{OP_LOAD, F3_W, 1'b0, 5'd9, 5'd0, 5'd0, 32'hffff_ffff}, 1'b0, '0);
		add_row('{OP_LOAD, F3_H, 1'b0, 5'd10, 5'd0, 5'd0, 32'd1}, 1'b0, '0);
		add_row('{OP_LOAD, F3_BU, 1'b0, 5'd11, 5'd0, 5'd0, 32'd2}, 1'b0, '0);
		add_row('{OP_BRANCH, F3_BLTU, 1'b0, 5'd0, 5'd0, 5'd1, 32'h0000_1ffe}, 1'b0, '0);
		add_row('{OP_BRANCH, F3_BGE, 1'b0, 5'd0, 5'd1, 5'd0, 32'h0000_0010}, 1'b0, '0);
		add_row('{OP_JAL, 3'd0, 1'b0, 5'd12, 5'd0, 5'd0, 32'h0010_0000}, 1'b0, '0);
		add_row('{OP_JALR, 3'd0, 1'b0, 5'd13, 5'd1, 5'd0, 32'h0000_07ff}, 1'b0, '0);

		repeat (12)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[i]) begin
			if (dir_tab[i].fixed) begin
				fx_r = dir_tab[i].r;
				send(dir_tab[i].w);
				if (results_due[$] !== fx_r) begin
					errors++;
					$display("%0t: row %0d exp %h got %h", $time, i, fx_r, results_due[$]);
				end
			end else
				send(dir_tab[i].w);
		end
		drain();

		// long receiver stall while words keep coming
		fork
			begin
				hold_rsp = 1'b1;
				repeat (200)
					@(posedge clk);
				hold_rsp = 1'b0;
			end
			for (int i = 0; i < 20; i++)
				send(rand_word());
		join

		for (int i = 0; i < N_RAND; ) begin
			burst = $urandom_range(1, 30);
			for (int j = 0; j < burst && i < N_RAND; j++, i++)
				send(rand_word());
			if ($urandom_range(0, 9) == 0)
				drain();
			else
				send_gap($urandom_range(0, 4));
		end

		// halt through ecall with a7 = 10, then words while halted
		send('{OP_OPIMM, F3_ADD, 1'b0, REG_A7, 5'd0, 5'd0, CALL_EXIT});
		send('{OP_SYSTEM, 3'd0, 1'b0, 5'd0, 5'd0, 5'd0, 32'd0});
		for (int i = 0; i < 5; i++) begin
			w = rand_word();
			send(w);
		end
		drain();
		repeat (20)
			@(posedge clk);

		$display("Sent %0d words, checked %0d results incl. stall, drain and halt phases.",
			n_words, n_results);
		if (errors == 0 && results_due.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
